/* rtl/core/dcsg_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, tables, types and elaboration-time helpers for the DDS CORDIC generator.
package dcsg_pkg;

    // Input dither field width
    localparam int DITHER_BITS = 31;

    // Configuration reset values
    localparam logic [63:0] TUNING_RESET = 64'd10995116277;
    localparam logic [63:0] START_RESET  = 64'd0;

    // Fixed-point constants are given in units of 1e-8
    localparam longint SCALE_E8 = 64'sd100000000;
    localparam longint X0_E8    = 64'sd60725294;

    // Angle scale pi/2 / (2^F - 1): 3141592 / 2000000 reduced.
    // 3141592 = 8 * 392699 and 2000000 = 128 * 15625, leaving a net 2^-4.
    localparam longint PI_ODD       = 64'sd392699;
    localparam longint HALF_DEN_ODD = 64'sd15625;
    localparam int     ANGLE_POW2   = 4;

    // Reciprocal shift for the angle scale estimate
    localparam int MAGIC_SHIFT = 32;

    // atan(2^-i), floor, scaled by 2^30
    localparam int ATAN_ENTRIES = 18;
    localparam int ATAN_FRAC    = 30;
    localparam longint ATAN_Q30 [ATAN_ENTRIES] = '{
        64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
        64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
        64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
        64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767,
        64'sd16383,     64'sd8191
    };

    // Sinc compensation taps in units of 1e-8
    localparam int COEF_ENTRIES = 9;
    localparam longint COEF_E8 [COEF_ENTRIES] = '{
        64'sd170522,   -64'sd583712,  64'sd1786389, -64'sd6833815, 64'sd81251125,
        -64'sd6833815, 64'sd1786389,  -64'sd583712, 64'sd170522
    };

    // Configuration register indexes
    typedef enum logic {
        REG_TUNING_WORD = 1'b0,
        REG_START_PHASE = 1'b1
    } cfg_reg_t;

    // Quadrant codes from the top two phase bits
    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // Control that travels beside the data down the pipeline
    typedef struct packed {
        logic  valid;
        quad_t quad;
    } stage_ctrl_t;

    // floor(c * 1e-8 * 2^frac)
    function automatic longint to_fix(input longint c, input int frac);
        longint num;
        num = c * (64'sd1 <<< frac);
        if (num >= 0) begin
            return num / SCALE_E8;
        end
        return -((-num + SCALE_E8 - 1) / SCALE_E8);
    endfunction

    // Rotation angle of one CORDIC stage; deep stages rotate by zero
    function automatic longint atan_fix(input int stage, input int frac);
        if (stage < ATAN_ENTRIES) begin
            return ATAN_Q30[stage] >>> (ATAN_FRAC - frac);
        end
        return 64'sd0;
    endfunction

    // FIR coefficient of one tap; taps past the table are zero
    function automatic longint coef_fix(input int tap, input int frac);
        if (tap < COEF_ENTRIES) begin
            return to_fix(COEF_E8[tap], frac);
        end
        return 64'sd0;
    endfunction

endpackage

/* rtl/core/dcsg_cordic_cell.sv */
`timescale 1ns / 1ps
// One rotation-mode CORDIC stage with its pipeline register.
module dcsg_cordic_cell #(
    parameter int SAMPLE_BITS = 14,
    parameter int STAGE       = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ce,
    input  dcsg_pkg::stage_ctrl_t         ctrl_in,
    input  logic signed [SAMPLE_BITS-1:0] x_in,
    input  logic signed [SAMPLE_BITS-1:0] y_in,
    input  logic signed [SAMPLE_BITS-1:0] z_in,
    output dcsg_pkg::stage_ctrl_t         ctrl_out,
    output logic signed [SAMPLE_BITS-1:0] x_out,
    output logic signed [SAMPLE_BITS-1:0] y_out,
    output logic signed [SAMPLE_BITS-1:0] z_out
);

    localparam int FRAC_BITS = SAMPLE_BITS - 2;
    localparam logic signed [SAMPLE_BITS-1:0] ANGLE =
        SAMPLE_BITS'(dcsg_pkg::atan_fix(STAGE, FRAC_BITS));

    dcsg_pkg::stage_ctrl_t         ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] x_reg, y_reg, z_reg;
    logic signed [SAMPLE_BITS-1:0] x_next, y_next, z_next;
    logic signed [SAMPLE_BITS-1:0] x_sh, y_sh;
    logic                          rot_pos;

    // Micro-rotation; direction is negative when the residual angle is not above zero
    always_comb begin
        rot_pos = (z_in > 0);
        x_sh    = x_in >>> STAGE;
        y_sh    = y_in >>> STAGE;
        if (rot_pos) begin
            x_next = x_in - y_sh;
            y_next = y_in + x_sh;
            z_next = z_in - ANGLE;
        end else begin
            x_next = x_in + y_sh;
            y_next = y_in - x_sh;
            z_next = z_in + ANGLE;
        end
    end

    // Stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg.valid <= 1'b0;
        end else if (ce) begin
            ctrl_reg <= ctrl_in;
        end
    end

    // Stage data
    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;

endmodule

/* rtl/core/dcsg_fir_cell.sv */
`timescale 1ns / 1ps
// One tap of the transposed sinc-compensation FIR.
module dcsg_fir_cell #(
    parameter int SAMPLE_BITS = 14,
    parameter int TAP         = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_en,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [SAMPLE_BITS-1:0] partial_in,
    output logic signed [SAMPLE_BITS-1:0] partial_out
);

    localparam int FRAC_BITS = SAMPLE_BITS - 2;
    localparam logic signed [SAMPLE_BITS-1:0] COEF =
        SAMPLE_BITS'(dcsg_pkg::coef_fix(TAP, FRAC_BITS));

    logic signed [2*SAMPLE_BITS-1:0] product;
    logic signed [2*SAMPLE_BITS-1:0] product_sh;
    logic signed [SAMPLE_BITS-1:0]   partial_reg;
    logic signed [SAMPLE_BITS-1:0]   partial_next;

    // Truncated product plus the partial sum handed down from the older taps
    always_comb begin
        product      = sample_in * COEF;
        product_sh   = product >>> FRAC_BITS;
        partial_next = $signed(product_sh[SAMPLE_BITS-1:0]) + partial_in;
    end

    // Partial sums start at zero, matching an all-zero history
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
        end else if (shift_en) begin
            partial_reg <= partial_next;
        end
    end

    assign partial_out = partial_reg;

endmodule

/* rtl/core/dds_cordic_sine_generator.sv */
`timescale 1ns / 1ps
// Top level: phase accumulator, angle scaling, CORDIC cell chain, quadrant map, FIR, output skid.
//
//  channel   dir   handshake          payload
//  s_        in    s_tvalid/s_tready  s_tdata: dither; s_tuser: resync
//  m_        out   m_tvalid/m_tready  m_tdata: dac_sin, dac_cos, raw_sin, raw_cos
//  cfg_      in    cfg_wr_en          cfg_index, cfg_wdata (no read-back)
//
// One sample transfer per cycle while the skid is empty; the accumulator loop is one register.
// From input to output register the path runs through four registers of phase capture and
// angle scaling, one per CORDIC cell, then the quadrant map, FIR and output registers.
// Reset (aresetn low, synchronous) clears the accumulator, FIR partials and valids and
// loads the register defaults. A stalled output fills a one-entry skid first; only
// then does the pipeline stop and s_tready drop.
module dds_cordic_sine_generator #(
    parameter int PHASE_BITS    = 40,
    parameter int SAMPLE_BITS   = 14,
    parameter int CORDIC_STAGES = 14,
    parameter int FILTER_ORDER  = 8,
    localparam int SDATA_W      = ((dcsg_pkg::DITHER_BITS + 7) / 8) * 8,
    localparam int MDATA_W      = ((4 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input samples
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SDATA_W-1:0]    s_tdata,   // [30:0] dither (signed), then zero fill
    input  logic [0:0]            s_tuser,   // [0] resync
    // Output samples
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [MDATA_W-1:0]    m_tdata,   // dac_sin, dac_cos, raw_sin, raw_cos, zero fill
    // Configuration writes
    input  logic                  cfg_wr_en,
    input  logic [0:0]            cfg_index,
    input  logic [PHASE_BITS-1:0] cfg_wdata
);

    localparam int FRAC_BITS = SAMPLE_BITS - 2;
    localparam int TAPS      = FILTER_ORDER + 1;
    localparam int MAGIC_W   = 34;
    localparam int EST_W     = FRAC_BITS + MAGIC_W;
    localparam int REM_W     = FRAC_BITS + 32;

    // Angle scale p * NUM / DEN, estimated by a reciprocal and corrected by one compare
    localparam logic [63:0] ANG_NUM =
        64'(dcsg_pkg::PI_ODD) << (FRAC_BITS - dcsg_pkg::ANGLE_POW2);
    localparam logic [63:0] ANG_DEN =
        64'((64'd1 << FRAC_BITS) - 64'd1) * 64'(dcsg_pkg::HALF_DEN_ODD);
    localparam logic [63:0] ANG_MAGIC = (ANG_NUM << dcsg_pkg::MAGIC_SHIFT) / ANG_DEN;

    localparam logic signed [SAMPLE_BITS-1:0] X0 =
        SAMPLE_BITS'(dcsg_pkg::to_fix(dcsg_pkg::X0_E8, FRAC_BITS));

    // ---------------------------------------------------------------
    // Configuration registers
    logic [PHASE_BITS-1:0] tuning_word_reg;
    logic [PHASE_BITS-1:0] start_phase_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tuning_word_reg <= PHASE_BITS'(dcsg_pkg::TUNING_RESET);
            start_phase_reg <= PHASE_BITS'(dcsg_pkg::START_RESET);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dcsg_pkg::REG_TUNING_WORD: tuning_word_reg <= cfg_wdata;
                dcsg_pkg::REG_START_PHASE: start_phase_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: the pipeline moves whenever the skid is empty
    logic ce;
    logic s_accept;
    logic skid_valid_reg;
    logic m_valid_reg;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;
    assign s_accept = s_tvalid && ce;

    // ---------------------------------------------------------------
    // Phase accumulator and capture stage
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [63:0]           dither_ext;

    dcsg_pkg::stage_ctrl_t s0_ctrl_reg;
    logic [FRAC_BITS-1:0]  s0_angle_reg;

    always_comb begin
        phase_cur      = s_tuser[0] ? start_phase_reg : phase_acc_reg;
        dither_ext     = 64'($signed(s_tdata[dcsg_pkg::DITHER_BITS-1:0]));
        phase_acc_next = phase_cur + tuning_word_reg + dither_ext[PHASE_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_acc_reg     <= '0;
            s0_ctrl_reg.valid <= 1'b0;
        end else begin
            if (s_accept) begin
                phase_acc_reg <= phase_acc_next;
            end
            if (ce) begin
                s0_ctrl_reg.valid <= s_tvalid;
                s0_ctrl_reg.quad  <= dcsg_pkg::quad_t'(phase_cur[PHASE_BITS-1 -: 2]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s0_angle_reg <= phase_cur[PHASE_BITS-3 -: FRAC_BITS];
        end
    end

    // ---------------------------------------------------------------
    // Angle scaling, stage 1: reciprocal estimate (low by at most one)
    logic [EST_W-1:0]      est_prod;
    dcsg_pkg::stage_ctrl_t s1_ctrl_reg;
    logic [FRAC_BITS-1:0]  s1_angle_reg;
    logic [FRAC_BITS:0]    s1_est_reg;

    assign est_prod = EST_W'(s0_angle_reg) * EST_W'(ANG_MAGIC);

    // Angle scaling, stage 2: exact numerator and estimate times denominator
    dcsg_pkg::stage_ctrl_t s2_ctrl_reg;
    logic [REM_W-1:0]      s2_num_reg;
    logic [REM_W-1:0]      s2_den_reg;
    logic [FRAC_BITS:0]    s2_est_reg;

    // Angle scaling, stage 3: correction, result enters the CORDIC chain
    logic [REM_W-1:0]              ang_rem;
    logic [FRAC_BITS:0]            ang_fixed;
    dcsg_pkg::stage_ctrl_t         s3_ctrl_reg;
    logic signed [SAMPLE_BITS-1:0] s3_z_reg;

    always_comb begin
        ang_rem   = s2_num_reg - s2_den_reg;
        ang_fixed = s2_est_reg + (FRAC_BITS+1)'(ang_rem >= REM_W'(ANG_DEN));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctrl_reg.valid <= 1'b0;
            s2_ctrl_reg.valid <= 1'b0;
            s3_ctrl_reg.valid <= 1'b0;
        end else if (ce) begin
            s1_ctrl_reg <= s0_ctrl_reg;
            s2_ctrl_reg <= s1_ctrl_reg;
            s3_ctrl_reg <= s2_ctrl_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            s1_angle_reg <= s0_angle_reg;
            s1_est_reg   <= est_prod[dcsg_pkg::MAGIC_SHIFT +: FRAC_BITS+1];
            s2_num_reg   <= REM_W'(s1_angle_reg) * REM_W'(ANG_NUM);
            s2_den_reg   <= REM_W'(s1_est_reg) * REM_W'(ANG_DEN);
            s2_est_reg   <= s1_est_reg;
            s3_z_reg     <= SAMPLE_BITS'(ang_fixed);
        end
    end

    // ---------------------------------------------------------------
    // CORDIC cell chain
    dcsg_pkg::stage_ctrl_t         cctrl [0:CORDIC_STAGES];
    logic signed [SAMPLE_BITS-1:0] cx    [0:CORDIC_STAGES];
    logic signed [SAMPLE_BITS-1:0] cy    [0:CORDIC_STAGES];
    logic signed [SAMPLE_BITS-1:0] cz    [0:CORDIC_STAGES-1];

    assign cctrl[0] = s3_ctrl_reg;
    assign cx[0]    = X0;
    assign cy[0]    = '0;
    assign cz[0]    = s3_z_reg;

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
        if (g < CORDIC_STAGES - 1) begin : g_mid
            dcsg_cordic_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .STAGE       (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ce       (ce),
                .ctrl_in  (cctrl[g]),
                .x_in     (cx[g]),
                .y_in     (cy[g]),
                .z_in     (cz[g]),
                .ctrl_out (cctrl[g+1]),
                .x_out    (cx[g+1]),
                .y_out    (cy[g+1]),
                .z_out    (cz[g+1])
            );
        end else begin : g_last
            // Residual angle of the last cell is not needed
            dcsg_cordic_cell #(
                .SAMPLE_BITS (SAMPLE_BITS),
                .STAGE       (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ce       (ce),
                .ctrl_in  (cctrl[g]),
                .x_in     (cx[g]),
                .y_in     (cy[g]),
                .z_in     (cz[g]),
                .ctrl_out (cctrl[g+1]),
                .x_out    (cx[g+1]),
                .y_out    (cy[g+1]),
                .z_out    ()
            );
        end
    end

    // ---------------------------------------------------------------
    // Quadrant map
    logic signed [SAMPLE_BITS-1:0] map_sin, map_cos;
    logic signed [SAMPLE_BITS-1:0] raw_sin_reg, raw_cos_reg;
    logic                          q_valid_reg;

    always_comb begin
        case (cctrl[CORDIC_STAGES].quad)
            dcsg_pkg::QUAD_0: begin
                map_sin = cy[CORDIC_STAGES];
                map_cos = cx[CORDIC_STAGES];
            end
            dcsg_pkg::QUAD_1: begin
                map_sin = cx[CORDIC_STAGES];
                map_cos = -cy[CORDIC_STAGES];
            end
            dcsg_pkg::QUAD_2: begin
                map_sin = -cy[CORDIC_STAGES];
                map_cos = -cx[CORDIC_STAGES];
            end
            dcsg_pkg::QUAD_3: begin
                map_sin = -cx[CORDIC_STAGES];
                map_cos = cy[CORDIC_STAGES];
            end
            default: begin
                map_sin = cy[CORDIC_STAGES];
                map_cos = cx[CORDIC_STAGES];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_valid_reg <= 1'b0;
        end else if (ce) begin
            q_valid_reg <= cctrl[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            raw_sin_reg <= map_sin;
            raw_cos_reg <= map_cos;
        end
    end

    // ---------------------------------------------------------------
    // Transposed FIR rows; partials shift only on a real sample
    logic                          fir_shift;
    logic signed [SAMPLE_BITS-1:0] sin_part [0:TAPS];
    logic signed [SAMPLE_BITS-1:0] cos_part [0:TAPS];
    logic signed [SAMPLE_BITS-1:0] f_raw_sin_reg, f_raw_cos_reg;
    logic                          f_valid_reg;

    assign fir_shift      = ce && q_valid_reg;
    assign sin_part[TAPS] = '0;
    assign cos_part[TAPS] = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_fir
        dcsg_fir_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAP         (k)
        ) u_sin (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (fir_shift),
            .sample_in   (raw_sin_reg),
            .partial_in  (sin_part[k+1]),
            .partial_out (sin_part[k])
        );
        dcsg_fir_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .TAP         (k)
        ) u_cos (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .shift_en    (fir_shift),
            .sample_in   (raw_cos_reg),
            .partial_in  (cos_part[k+1]),
            .partial_out (cos_part[k])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (ce) begin
            f_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f_raw_sin_reg <= raw_sin_reg;
            f_raw_cos_reg <= raw_cos_reg;
        end
    end

    // ---------------------------------------------------------------
    // Output register with one-entry skid
    logic [MDATA_W-1:0] pipe_data;
    logic [MDATA_W-1:0] m_data_reg;
    logic [MDATA_W-1:0] skid_data_reg;
    logic               out_free;

    assign pipe_data = MDATA_W'({f_raw_cos_reg, f_raw_sin_reg, cos_part[0], sin_part[0]});
    assign out_free  = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= f_valid_reg;
            end
        end else if (f_valid_reg && ce) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_valid_reg ? skid_data_reg : pipe_data;
        end else if (f_valid_reg && ce) begin
            skid_data_reg <= pipe_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------------------------------------------------------
    // Assertions

    // The skid only holds data behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid holds data while output register is empty");

    // The skid fills only when the output was stalled
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(m_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // The reciprocal estimate is never high and at most one low
    a_angle_estimate: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_ctrl_reg.valid |-> (ang_rem < REM_W'(ANG_DEN << 1)))
        else $error("angle scale estimate out of range");

    // A resync transfer restarts the accumulator from start_phase
    a_resync_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && s_tuser[0]) |=>
            (phase_acc_reg == $past(start_phase_reg + tuning_word_reg
                                    + dither_ext[PHASE_BITS-1:0])))
        else $error("phase accumulator did not restart on resync");

endmodule
